[design/srop_pkg.sv]
// Shared types and constants of the static route option parser.
`timescale 1ns / 1ps
package srop_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_FORMAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTES_ALLOWED = 1'd1;

    // Route formats.
    localparam logic FMT_CLASSLESS = 1'b0;
    localparam logic FMT_CLASSFUL = 1'b1;

    // Result kinds.
    localparam logic KIND_ROUTE = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Record field phases.
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_DEST = 2'd1;
    localparam logic [1:0] PH_GW = 2'd2;

    // Depth of the queue between parser and result formatter.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       end_of_option;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] route_destination;
        logic [31:0] route_mask;
        logic [31:0] route_gateway;
        logic        option_status;
        logic [5:0]  routes_accepted;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic       route_format;
        logic [5:0] routes_allowed;
    } t_cfg;

    // What one accepted word leaves for the result formatter.
    typedef struct packed {
        logic        has_route;
        logic        has_summary;
        logic        fmt;
        logic [5:0]  prefix_width;
        logic [31:0] dest_shift;
        logic [31:0] gateway;
        logic        status;
        logic [5:0]  count;
    } t_desc;

endpackage

[design/srop_queue.sv]
// Short descriptor queue between the parser and the result formatter.
`timescale 1ns / 1ps
module srop_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  srop_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output srop_pkg::t_desc o_desc,
    output logic           o_empty
);
    import srop_pkg::*;

    t_desc           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_AW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_desc  = r_mem[r_rp];

    // Pointer and fill count update.
    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule

[design/srop_front.sv]
// Byte parser: tracks record phase and counts, and emits one descriptor per event word.
`timescale 1ns / 1ps
module srop_front #(
    parameter int MAX_ROUTES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  srop_pkg::t_in_item i_item,
    input  srop_pkg::t_cfg    i_cfg,
    output logic              o_desc_push,
    output srop_pkg::t_desc   o_desc
);
    import srop_pkg::*;

    localparam logic [7:0] MaxRoutes8 = 8'(MAX_ROUTES);

    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_left, n_left;
    logic [5:0]  r_pw, n_pw;
    logic [31:0] r_dest, n_dest;
    logic [31:0] r_gw, n_gw;
    logic [5:0]  r_count, n_count;
    logic [2:0]  r_len8, n_len8;
    logic        r_err, n_err;
    logic        r_lim, n_lim;

    logic [5:0]  lim;
    logic [2:0]  left_dec;
    logic [8:0]  ib_sum;
    logic [2:0]  ib;
    logic        route_now;
    logic        sum_err;
    logic [7:0]  b;

    assign b = i_item.option_byte;

    // Next parser state for the word being accepted.
    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_pw      = r_pw;
        n_dest    = r_dest;
        n_gw      = r_gw;
        n_count   = r_count;
        n_len8    = r_len8 + 3'd1;
        n_err     = r_err;
        n_lim     = r_lim;
        route_now = 1'b0;
        sum_err   = 1'b0;

        // Effective route limit is saturated at the build-time maximum.
        lim = i_cfg.routes_allowed;
        if ({2'b00, i_cfg.routes_allowed} > MaxRoutes8) begin
            lim = MaxRoutes8[5:0];
        end
        if (lim == '0) begin
            n_err = 1'b1;
        end else if (r_count >= lim) begin
            n_lim = 1'b1;
        end

        left_dec = (r_left != '0) ? r_left - 3'd1 : 3'd0;
        ib_sum   = {1'b0, b} + 9'd7;
        ib       = ib_sum[5:3];

        if (!n_err && !n_lim) begin
            if (r_phase == PH_DEST) begin
                n_dest = {r_dest[23:0], b};
                n_left = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_GW;
                    n_left  = 3'd4;
                end
            end else if (r_phase == PH_GW) begin
                n_gw   = {r_gw[23:0], b};
                n_left = left_dec;
                if (left_dec == '0) begin
                    route_now = 1'b1;
                    n_phase   = PH_START;
                    n_count   = r_count + 6'd1;
                    if (n_count >= lim) begin
                        n_lim = 1'b1;
                    end
                end
            end else begin
                // Record start; the unused phase code lands here too.
                n_gw = '0;
                if (i_cfg.route_format == FMT_CLASSFUL) begin
                    n_dest  = {24'd0, b};
                    n_left  = 3'd3;
                    n_phase = PH_DEST;
                end else if (b > 8'd32) begin
                    n_err   = 1'b1;
                    n_phase = PH_START;
                end else begin
                    n_pw   = b[5:0];
                    n_dest = '0;
                    if (ib == '0) begin
                        n_phase = PH_GW;
                        n_left  = 3'd4;
                    end else begin
                        n_phase = PH_DEST;
                        n_left  = ib;
                    end
                end
            end
        end

        // End of option status.
        sum_err = n_err;
        if (i_cfg.route_format == FMT_CLASSLESS && n_phase != PH_START && !n_lim) begin
            sum_err = 1'b1;
        end
        if (i_cfg.route_format == FMT_CLASSFUL && n_len8 != '0) begin
            sum_err = 1'b1;
        end

        o_desc.has_route    = route_now;
        o_desc.has_summary  = i_item.end_of_option;
        o_desc.fmt          = i_cfg.route_format;
        o_desc.prefix_width = r_pw;
        o_desc.dest_shift   = r_dest;
        o_desc.gateway      = n_gw;
        o_desc.status       = sum_err;
        o_desc.count        = sum_err ? 6'd0 : n_count;

        o_desc_push = i_accept && (route_now || i_item.end_of_option);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_left  <= '0;
            r_pw    <= '0;
            r_dest  <= '0;
            r_gw    <= '0;
            r_count <= '0;
            r_len8  <= '0;
            r_err   <= 1'b0;
            r_lim   <= 1'b0;
        end else if (i_accept) begin
            if (i_item.end_of_option) begin
                // The summary closes the option; start the next one clean.
                r_phase <= PH_START;
                r_left  <= '0;
                r_pw    <= '0;
                r_dest  <= '0;
                r_gw    <= '0;
                r_count <= '0;
                r_len8  <= '0;
                r_err   <= 1'b0;
                r_lim   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_pw    <= n_pw;
                r_dest  <= n_dest;
                r_gw    <= n_gw;
                r_count <= n_count;
                r_len8  <= n_len8;
                r_err   <= n_err;
                r_lim   <= n_lim;
            end
        end
    end

    // The parser never enters the unused phase code.
    a_phase_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("parser reached unused phase");

    // Route count stays within the build-time maximum.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_ROUTES)
        else $error("route count above maximum");

    // A summary leaves the parser at record start with a zero count.
    a_summary_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.end_of_option) |=> (r_phase == PH_START && r_count == '0))
        else $error("option state not cleared after summary");

    // A malformed option never reports routes.
    a_error_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_desc_push && o_desc.has_summary && o_desc.status) |-> (o_desc.count == '0))
        else $error("malformed option reports routes");

endmodule

[design/srop_back.sv]
// Result formatter: turns descriptors into route and summary words in an output register.
`timescale 1ns / 1ps
module srop_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srop_pkg::t_desc    i_desc,
    input  logic               i_desc_empty,
    output logic               o_desc_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output srop_pkg::t_out_item o_result
);
    import srop_pkg::*;

    logic      r_valid, n_valid;
    logic      r_second, n_second;
    t_out_item r_out, n_out;

    logic        load;
    logic [5:0]  pw;
    logic [6:0]  ib_sum;
    logic [2:0]  ib;
    logic [5:0]  dsh;
    logic [31:0] dest_cl;
    logic [31:0] mask_cl;
    logic [31:0] mask_cf;
    logic        stop;
    t_out_item   route_word;
    t_out_item   sum_word;

    assign o_empty  = !r_valid;
    assign o_result = r_out;

    // Destination and mask of the head route.
    always_comb begin
        pw      = (i_desc.prefix_width > 6'd32) ? 6'd32 : i_desc.prefix_width;
        ib_sum  = {1'b0, pw} + 7'd7;
        ib      = ib_sum[5:3];
        dsh     = {3'd4 - ib, 3'b000};
        dest_cl = (ib == '0) ? 32'd0 : (i_desc.dest_shift << dsh);
        mask_cl = (pw == '0) ? 32'd0 : ({32{1'b1}} << (6'd32 - pw));

        // Classful mask clears bytes below the lowest nonzero destination byte.
        mask_cf = {32{1'b1}};
        stop    = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (!stop) begin
                if (i_desc.dest_shift[8*k +: 8] != 8'd0) begin
                    stop = 1'b1;
                end else begin
                    mask_cf[8*k +: 8] = 8'd0;
                end
            end
        end

        route_word.result_kind       = KIND_ROUTE;
        route_word.route_destination =
            (i_desc.fmt == FMT_CLASSFUL) ? i_desc.dest_shift : dest_cl;
        route_word.route_mask        = (i_desc.fmt == FMT_CLASSFUL) ? mask_cf : mask_cl;
        route_word.route_gateway     = i_desc.gateway;
        route_word.option_status     = 1'b0;
        route_word.routes_accepted   = '0;
        route_word.last_of_run       = !i_desc.has_summary;

        sum_word.result_kind       = KIND_SUMMARY;
        sum_word.route_destination = '0;
        sum_word.route_mask        = '0;
        sum_word.route_gateway     = '0;
        sum_word.option_status     = i_desc.status;
        sum_word.routes_accepted   = i_desc.count;
        sum_word.last_of_run       = 1'b1;
    end

    // Output register refill from the queue head.
    always_comb begin
        load       = !r_valid || i_pop;
        n_valid    = r_valid;
        n_second   = r_second;
        n_out      = r_out;
        o_desc_pop = 1'b0;
        if (load) begin
            n_valid = !i_desc_empty;
            if (!i_desc_empty) begin
                if (i_desc.has_route && !r_second) begin
                    n_out = route_word;
                    if (i_desc.has_summary) begin
                        n_second = 1'b1;
                    end else begin
                        o_desc_pop = 1'b1;
                    end
                end else begin
                    n_out      = sum_word;
                    n_second   = 1'b0;
                    o_desc_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // A summary word always closes its run.
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.result_kind == KIND_SUMMARY) |-> r_out.last_of_run)
        else $error("summary word not marked last");

    // The second half of a descriptor is pending only behind a route word.
    a_second_after_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (r_valid && r_out.result_kind == KIND_ROUTE && !r_out.last_of_run))
        else $error("pending summary without route word");

    // The queue is only drained when it holds something.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_desc_pop |-> !i_desc_empty)
        else $error("descriptor popped from empty queue");

endmodule

[design/static_route_option_parser_top.sv]
// Top level of the static route option parser: configuration registers and module wiring.
`timescale 1ns / 1ps
// Decodes the payload of a DHCP route option, one byte word per push, in either the
// classless width-prefixed format or the classful eight-byte format, and delivers a
// word per decoded route plus a summary word (status and route count) on the byte
// marked end of option. A byte is taken in every cycle while full is low; the parser
// updates its state and passes a descriptor into a four-entry queue.
// The result side delivers one word per cycle from its output register while the
// consumer keeps popping, so a byte that completes a route and also ends the option
// yields two output words; full rises only when the queue holds four descriptors
// the consumer has not drained. With the result side idle, a route passes from the
// edge that accepts its last byte through the descriptor queue into the output register.
// Configuration writes are always ready and take effect on the next byte.
module static_route_option_parser_top #(
    parameter int MAX_ROUTES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  srop_pkg::t_in_item                  i_item,
    output logic                                empty,
    input  logic                                pop,
    output srop_pkg::t_out_item                 o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [srop_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [srop_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import srop_pkg::*;

    t_cfg  r_cfg;
    logic  accept;
    logic  desc_push;
    t_desc desc_in;
    t_desc desc_head;
    logic  desc_empty;
    logic  desc_pop;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.route_format   <= FMT_CLASSLESS;
            r_cfg.routes_allowed <= 6'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ROUTE_FORMAT:   r_cfg.route_format   <= i_cfg_data[0];
                CFG_ROUTES_ALLOWED: r_cfg.routes_allowed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    srop_front #(
        .MAX_ROUTES(MAX_ROUTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .o_desc_push(desc_push),
        .o_desc     (desc_in)
    );

    srop_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (desc_push),
        .i_desc (desc_in),
        .o_full (full),
        .i_pop  (desc_pop),
        .o_desc (desc_head),
        .o_empty(desc_empty)
    );

    srop_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (desc_head),
        .i_desc_empty(desc_empty),
        .o_desc_pop  (desc_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule
